### rtl/acc_isa_pkg.sv
// ----------------------------------------------------------------------------
// acc_isa_pkg
// Shared types and constants for the accumulator instruction set executor.
// ----------------------------------------------------------------------------
package acc_isa_pkg;

  localparam int ADDR_W    = 12;
  localparam int WORD_W    = 16;
  localparam int MEM_AW    = 12;
  localparam int MEM_WORDS = 1 << MEM_AW;

  typedef enum logic [1:0] {
    FUNC_WRITE = 2'd0,
    FUNC_EXEC  = 2'd1,
    FUNC_READ  = 2'd2,
    FUNC_NONE  = 2'd3
  } func_t;

  typedef enum logic [3:0] {
    OP_LODD = 4'd0,
    OP_STOD = 4'd1,
    OP_ADDD = 4'd2,
    OP_SUBD = 4'd3,
    OP_JPOS = 4'd4,
    OP_JZER = 4'd5,
    OP_JUMP = 4'd6,
    OP_LOCO = 4'd7,
    OP_LODL = 4'd8,
    OP_STOL = 4'd9,
    OP_ADDL = 4'd10,
    OP_SUBL = 4'd11,
    OP_JNEG = 4'd12,
    OP_JNZE = 4'd13,
    OP_CALL = 4'd14,
    OP_EXT  = 4'd15
  } op_t;

  typedef struct packed {
    func_t               func;
    logic [ADDR_W-1:0]   addr;
    logic [WORD_W-1:0]   data;
  } req_t;

  typedef struct packed {
    logic [ADDR_W-1:0]        pc;
    logic signed [WORD_W-1:0] ac;
    logic [ADDR_W-1:0]        sp;
    logic                     halted;
    logic [WORD_W-1:0]        read_data;
  } rsp_t;

  typedef struct packed {
    logic latch_in;
    logic clr_wr;
    logic wr_in;
    logic rd_addr;
    logic rd_opnd;
    logic ld_ir;
    logic exec;
    logic finish;
    logic ld_rdata;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last;
  } dp_status_t;

endpackage

### rtl/accumulator_isa_executor.sv
// ----------------------------------------------------------------------------
// accumulator_isa_executor
// Accumulator instruction set executor: memory write, memory read or
// execution of one instruction per transfer.
// ----------------------------------------------------------------------------
//  channel   signals               transfer
//  request   start, busy, req      start high and busy low at a clock edge
//  result    done, rsp             done high for one cycle, always taken
//
//  execute runs fetch, operand read and execute over the synchronous memory
//  (one read, one write port); write and unused code end in their own state.
//  a new request is taken in the last cycle of the previous one.
//  after reset the memory is cleared one word a cycle, busy until all words
//  are clear. results appear in the cycle after the last step; no stall.
// ----------------------------------------------------------------------------
module accumulator_isa_executor
  import acc_isa_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  req_t req,
  output logic done,
  output rsp_t rsp
);

  dp_cmd_t    cmd;
  dp_status_t sts;

  acc_isa_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .func  (req.func),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  acc_isa_dp u_dp (
    .clk (clk),
    .rst (rst),
    .req (req),
    .cmd (cmd),
    .sts (sts),
    .rsp (rsp)
  );

  a_clear_after_reset: assert property (@(posedge clk) rst |=> busy)
    else $error("not busy clearing memory after reset");

  a_exec_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && req.func == FUNC_EXEC) |-> ##4 done)
    else $error("execute result late");

  a_write_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && req.func == FUNC_WRITE) |=> ##1 done)
    else $error("write result late");

  a_rdata_zero: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && req.func == FUNC_EXEC) |-> ##4 (rsp.read_data == '0))
    else $error("read data not zero after execute");

endmodule

### rtl/acc_isa_ctrl.sv
// ----------------------------------------------------------------------------
// acc_isa_ctrl
// Sequencer: memory clear after reset, item dispatch and per-step commands.
// ----------------------------------------------------------------------------
module acc_isa_ctrl
  import acc_isa_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  func_t      func,
  input  dp_status_t sts,
  output dp_cmd_t    cmd,
  output logic       busy,
  output logic       done
);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_WRITE,
    S_FETCH,
    S_DECODE,
    S_EXEC,
    S_READ,
    S_READ_DONE,
    S_NOP
  } state_t;

  state_t state;
  state_t state_next;
  logic   final_step;
  logic   accept;

  function automatic state_t dispatch(func_t f);
    state_t s;
    unique case (f)
      FUNC_WRITE: s = S_WRITE;
      FUNC_EXEC:  s = S_FETCH;
      FUNC_READ:  s = S_READ;
      default:    s = S_NOP;
    endcase
    return s;
  endfunction

  assign final_step = (state == S_WRITE) || (state == S_EXEC) ||
                      (state == S_READ_DONE) || (state == S_NOP);
  assign busy   = !((state == S_IDLE) || final_step);
  assign accept = start && !busy;

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR:     if (sts.clr_last) state_next = S_IDLE;
      S_IDLE:      if (start) state_next = dispatch(func);
      S_FETCH:     state_next = S_DECODE;
      S_DECODE:    state_next = S_EXEC;
      S_READ:      state_next = S_READ_DONE;
      S_WRITE,
      S_EXEC,
      S_READ_DONE,
      S_NOP:       state_next = start ? dispatch(func) : S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.latch_in = accept;
    cmd.clr_wr   = (state == S_CLEAR);
    cmd.wr_in    = (state == S_WRITE);
    cmd.rd_addr  = (state == S_READ);
    cmd.rd_opnd  = (state == S_DECODE);
    cmd.ld_ir    = (state == S_DECODE);
    cmd.exec     = (state == S_EXEC);
    cmd.finish   = final_step;
    cmd.ld_rdata = (state == S_READ_DONE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= final_step;
    end
  end

endmodule

### rtl/acc_isa_dp.sv
// ----------------------------------------------------------------------------
// acc_isa_dp
// Datapath: main memory, architectural registers, operand address and alu.
// ----------------------------------------------------------------------------
module acc_isa_dp
  import acc_isa_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  req_t       req,
  input  dp_cmd_t    cmd,
  output dp_status_t sts,
  output rsp_t       rsp
);

  logic [WORD_W-1:0] mem [MEM_WORDS];
  logic [WORD_W-1:0] mem_q;

  logic [ADDR_W-1:0] addr_q;
  logic [WORD_W-1:0] data_q;
  logic [WORD_W-1:0] ir;
  logic [ADDR_W-1:0] pc;
  logic [WORD_W-1:0] ac;
  logic [ADDR_W-1:0] sp;
  logic              halt;
  logic [WORD_W-1:0] rdata;
  logic [MEM_AW-1:0] clr_cnt;

  logic [ADDR_W-1:0] ra;
  logic [ADDR_W-1:0] wa;
  logic [WORD_W-1:0] wd;
  logic              we;

  op_t               op;
  logic [ADDR_W-1:0] opnd;
  logic [ADDR_W-1:0] ex_addr;
  logic [ADDR_W-1:0] pc_inc;
  logic [ADDR_W-1:0] sp_dec;
  logic              neg;
  logic              zero;

  logic [ADDR_W-1:0] pc_next;
  logic [WORD_W-1:0] ac_next;
  logic [ADDR_W-1:0] sp_next;
  logic              halt_next;

  // sp-relative group is 8..11
  function automatic logic [ADDR_W-1:0] op_addr(logic [WORD_W-1:0] ins,
                                                logic [ADDR_W-1:0] s);
    logic [ADDR_W-1:0] a;
    if (ins[WORD_W-1] && !ins[WORD_W-2]) a = s + ins[ADDR_W-1:0];
    else a = ins[ADDR_W-1:0];
    return a;
  endfunction

  assign op      = op_t'(ir[WORD_W-1:WORD_W-4]);
  assign opnd    = ir[ADDR_W-1:0];
  assign ex_addr = op_addr(ir, sp);
  assign pc_inc  = pc + 1'b1;
  assign sp_dec  = sp - 1'b1;
  assign neg     = ac[WORD_W-1];
  assign zero    = (ac == '0);

  assign sts.clr_last = (clr_cnt == MEM_AW'(MEM_WORDS - 1));

  // memory port selection
  always_comb begin
    if (cmd.rd_opnd)      ra = op_addr(mem_q, sp);
    else if (cmd.rd_addr) ra = addr_q;
    else                  ra = pc;
  end

  always_comb begin
    we = 1'b0;
    wa = addr_q;
    wd = data_q;
    priority if (cmd.clr_wr) begin
      we = 1'b1;
      wa = ADDR_W'(clr_cnt);
      wd = '0;
    end else if (cmd.wr_in) begin
      we = 1'b1;
    end else if (cmd.exec && (op == OP_STOD || op == OP_STOL)) begin
      we = 1'b1;
      wa = ex_addr;
      wd = ac;
    end else if (cmd.exec && op == OP_CALL) begin
      we = 1'b1;
      wa = sp_dec;
      wd = WORD_W'(pc_inc);
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[wa[MEM_AW-1:0]] <= wd;
    mem_q <= mem[ra[MEM_AW-1:0]];
  end

  // execute
  always_comb begin
    pc_next   = pc_inc;
    ac_next   = ac;
    sp_next   = sp;
    halt_next = halt;
    unique case (op)
      OP_LODD, OP_LODL: ac_next = mem_q;
      OP_ADDD, OP_ADDL: ac_next = ac + mem_q;
      OP_SUBD, OP_SUBL: ac_next = ac - mem_q;
      OP_STOD, OP_STOL: ;
      OP_JPOS:          if (!neg) pc_next = opnd;
      OP_JZER:          if (zero) pc_next = opnd;
      OP_JUMP:          pc_next = opnd;
      OP_LOCO:          ac_next = WORD_W'(opnd);
      OP_JNEG:          if (neg) pc_next = opnd;
      OP_JNZE:          if (!zero) pc_next = opnd;
      OP_CALL: begin
        sp_next = sp_dec;
        pc_next = opnd;
      end
      default:          halt_next = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      addr_q <= req.addr;
      data_q <= req.data;
    end
    if (cmd.ld_ir) ir <= mem_q;
    if (cmd.finish) rdata <= cmd.ld_rdata ? mem_q : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc      <= '0;
      ac      <= '0;
      sp      <= '0;
      halt    <= 1'b0;
      clr_cnt <= '0;
    end else begin
      if (cmd.clr_wr) clr_cnt <= clr_cnt + 1'b1;
      if (cmd.exec) begin
        pc   <= pc_next;
        ac   <= ac_next;
        sp   <= sp_next;
        halt <= halt_next;
      end
    end
  end

  assign rsp.pc        = pc;
  assign rsp.ac        = ac;
  assign rsp.sp        = sp;
  assign rsp.halted    = halt;
  assign rsp.read_data = rdata;

endmodule
